>>> rtl/core/shamc_pkg.sv
// Shared types, command codes and the round constant table for the
// multi-lane SHA-256 compression engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package shamc_pkg;

  // Number of independent hash lanes.
  localparam int LANES  = 8;
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

  // Command codes of an input beat.
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_MSG  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Result kinds of an output beat.
  localparam logic RK_READ = 1'b0;
  localparam logic RK_DONE = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  lane;
    logic [2:0]  word_index;
    logic [31:0] data_word;
  } cmd_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  result_lane;
    logic [2:0]  result_index;
    logic [31:0] result_data;
  } rsp_t;

  // Controls from the sequencer to the round unit.
  typedef struct packed {
    logic w_shift;  // shift a message word into the schedule ring
    logic v_shift;  // shift a word into the working variables
    logic run;      // execute one compression round
  } round_ctl_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sha256_multilane_compress_top.sv
// Multi-lane SHA-256 compression engine top level: command decode, chaining
// and message memories, round sequencer and output register. Depends on
// shamc_pkg and shamc_round.
// Sequence: a load or a non-final message word is taken while idle; a read
// goes through READ to the output register; a lane's 16th message word runs
// FILL, ROUND, UPDATE and DONE, and DONE or READ waits for an output slot.
// Throughput: one load or message beat per cycle while idle; no command is
// taken during a read or a block, as the single round unit is shared.
// Reset (rst, synchronous, high) zeroes word counts and rsp_valid and makes chaining words read as zero.
`timescale 1ns / 1ps
`default_nettype none

module sha256_multilane_compress_top (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_ready,
  input  wire shamc_pkg::cmd_t  cmd,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output shamc_pkg::rsp_t       rsp
);

  localparam int LW    = shamc_pkg::LANE_W;
  localparam int CW_AW = LW + 3;  // chaining memory address: lane, word
  localparam int MB_AW = LW + 4;  // message memory address: lane, word

  // Sequencer states. FILL streams the block and the chaining words into the
  // round unit, ROUND runs the 64 rounds, UPDATE adds the result back into
  // the chaining memory, and DONE/READ wait for room in the output register.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_FILL   = 6'b000100,
    S_ROUND  = 6'b001000,
    S_UPDATE = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t      state;
  logic [5:0]  step;        // fill index, round number or write-back index
  logic [2:0]  lane_q;      // lane of the item in progress
  logic [2:0]  idx_q;       // word index of a pending read

  // Per-lane count of message words received for the current block.
  logic [3:0]  words_received [shamc_pkg::LANES];

  // Chaining words: one memory with a valid bit per entry so that reset
  // reads back as zero without a clearing pass.
  logic [31:0]                      cw_mem [shamc_pkg::LANES * 8];
  logic [shamc_pkg::LANES * 8 - 1:0] cw_vld;
  logic [31:0]                      cw_rd;
  logic                             cw_rd_vld;
  logic                             cw_we, cw_re;
  logic [CW_AW-1:0]                 cw_waddr, cw_raddr;
  logic [31:0]                      cw_wdata, cw_q;

  // Message buffer: each lane's 16 words, always written before being read.
  logic [31:0]      mb_mem [shamc_pkg::LANES * 16];
  logic [31:0]      mb_rd;
  logic             mb_we, mb_re;
  logic [MB_AW-1:0] mb_waddr, mb_raddr;

  logic                   accept, lane_ok, slot_free, block_end, rsp_load;
  logic [LW-1:0]          lane_in, lane_cur;
  logic [3:0]             cnt_cur;
  shamc_pkg::round_ctl_t  rctl;
  logic [31:0]            v_in, v_head;

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign lane_ok   = (32'(cmd.lane) < 32'(shamc_pkg::LANES));
  assign lane_in   = LW'(cmd.lane);
  assign lane_cur  = LW'(lane_q);
  assign cnt_cur   = words_received[lane_in];
  assign block_end = accept && lane_ok && (cmd.command == shamc_pkg::CMD_MSG) &&
                     (cnt_cur == 4'd15);
  assign slot_free = !rsp_valid || rsp_ready;
  // The output register takes a new beat in this cycle.
  assign rsp_load  = slot_free && ((state == S_READ) || (state == S_DONE));

  // A chaining word never loaded since reset reads as zero.
  assign cw_q = cw_rd_vld ? cw_rd : '0;

  // Memory port selection per state.
  always_comb begin
    cw_we    = 1'b0;
    cw_waddr = {lane_in, cmd.word_index};
    cw_wdata = cmd.data_word;
    cw_re    = 1'b0;
    cw_raddr = {lane_in, cmd.word_index};
    mb_we    = 1'b0;
    mb_waddr = {lane_in, cnt_cur};
    mb_re    = 1'b0;
    mb_raddr = {lane_cur, step[3:0]};
    unique case (state)
      S_IDLE: begin
        if (accept && lane_ok) begin
          cw_we = (cmd.command == shamc_pkg::CMD_LOAD);
          cw_re = (cmd.command == shamc_pkg::CMD_READ);
          mb_we = (cmd.command == shamc_pkg::CMD_MSG);
        end
      end
      S_FILL: begin
        mb_re    = (step < 6'd16);
        cw_re    = (step < 6'd8);
        cw_raddr = {lane_cur, step[2:0]};
      end
      S_UPDATE: begin
        // Read word i while word i-1 is summed and written back.
        cw_re    = (step < 6'd8);
        cw_raddr = {lane_cur, step[2:0]};
        cw_we    = (step != 6'd0);
        cw_waddr = {lane_cur, 3'(step - 6'd1)};
        cw_wdata = cw_q + v_head;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cw_we) begin
      cw_mem[cw_waddr] <= cw_wdata;
    end
    if (cw_re) begin
      cw_rd <= cw_mem[cw_raddr];
    end
    if (mb_we) begin
      mb_mem[mb_waddr] <= cmd.data_word;
    end
    if (mb_re) begin
      mb_rd <= mb_mem[mb_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cw_vld    <= '0;
      cw_rd_vld <= 1'b0;
    end else begin
      if (cw_we) begin
        cw_vld[cw_waddr] <= 1'b1;
      end
      if (cw_re) begin
        cw_rd_vld <= cw_vld[cw_raddr];
      end
    end
  end

  // Round unit controls. Read data is registered, so the
  // fill shifts run one step behind the reads. During write-back the working
  // variables rotate so that v_head always holds the word being summed.
  always_comb begin
    rctl.w_shift = (state == S_FILL) && (step != 6'd0);
    rctl.v_shift = ((state == S_FILL) || (state == S_UPDATE)) &&
                   (step != 6'd0) && (step <= 6'd8);
    rctl.run     = (state == S_ROUND);
    v_in         = (state == S_UPDATE) ? v_head : cw_q;
  end

  shamc_round u_round (
    .clk    (clk),
    .ctl    (rctl),
    .w_in   (mb_rd),
    .v_in   (v_in),
    .k      (shamc_pkg::round_k(step)),
    .v_head (v_head)
  );

  // Sequencer, word counts and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < shamc_pkg::LANES; i++) begin
        words_received[i] <= '0;
      end
    end else begin
      if (rsp_valid && rsp_ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && lane_ok) begin
            lane_q <= cmd.lane;
            idx_q  <= cmd.word_index;
            if (cmd.command == shamc_pkg::CMD_MSG) begin
              words_received[lane_in] <= cnt_cur + 4'd1;
              if (cnt_cur == 4'd15) begin
                state <= S_FILL;
                step  <= '0;
              end
            end else if (cmd.command == shamc_pkg::CMD_READ) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (slot_free) begin
            rsp_valid        <= 1'b1;
            rsp.result_kind  <= shamc_pkg::RK_READ;
            rsp.result_lane  <= lane_q;
            rsp.result_index <= idx_q;
            rsp.result_data  <= cw_q;
            state            <= S_IDLE;
          end
        end
        S_FILL: begin
          if (step == 6'd16) begin
            step  <= '0;
            state <= S_ROUND;
          end else begin
            step <= step + 6'd1;
          end
        end
        S_ROUND: begin
          step <= step + 6'd1;
          if (step == 6'd63) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          step <= step + 6'd1;
          if (step == 6'd8) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            rsp_valid        <= 1'b1;
            rsp.result_kind  <= shamc_pkg::RK_DONE;
            rsp.result_lane  <= lane_q;
            rsp.result_index <= '0;
            rsp.result_data  <= '0;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_round_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && step != 6'd63) |=>
      (state == S_ROUND && step == $past(step) + 6'd1))
    else $error("round counter skipped or left the round phase early");

  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (words_received[lane_cur] == 4'd0))
    else $error("word count of the compressing lane not cleared");

  a_block_start: assert property (@(posedge clk) disable iff (rst)
    block_end |=> (state == S_FILL && step == 6'd0))
    else $error("completed block did not start the fill phase");

  a_done_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.result_kind == shamc_pkg::RK_DONE) |->
      (rsp.result_index == 3'd0 && rsp.result_data == 32'd0))
    else $error("block-done beat carries nonzero index or data");
`endif

endmodule

`default_nettype wire

>>> rtl/core/shamc_round.sv
// SHA-256 round unit: working variables, 16-word schedule ring and one round
// of logic per cycle. Depends on shamc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shamc_round (
  input  wire logic                   clk,
  input  wire shamc_pkg::round_ctl_t  ctl,
  input  wire logic [31:0]            w_in,
  input  wire logic [31:0]            v_in,
  input  wire logic [31:0]            k,
  output logic [31:0]                 v_head
);

  logic [31:0] v [8];
  logic [31:0] w [16];

  logic [31:0] big_s1, big_s0, ch, maj, t1, t2;
  logic [31:0] sm0, sm1, w_new;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // w[0] is the schedule word of the current round; the word sixteen rounds
  // ahead is formed in parallel and enters at the tail of the ring.
  always_comb begin
    big_s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch     = (v[4] & v[5]) ^ (~v[4] & v[6]);
    big_s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj    = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1     = v[7] + big_s1 + ch + k + w[0];
    t2     = big_s0 + maj;
    sm0    = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    sm1    = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new  = w[0] + sm0 + sm1 + w[9];
  end

  always_ff @(posedge clk) begin
    if (ctl.w_shift || ctl.run) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= ctl.run ? w_new : w_in;
    end
    if (ctl.v_shift) begin
      for (int i = 0; i < 7; i++) begin
        v[i] <= v[i + 1];
      end
      v[7] <= v_in;
    end else if (ctl.run) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  assign v_head = v[0];

endmodule

`default_nettype wire

>>> tb/sv/sha256_multilane_compress_top_tb.sv
// Self-checking testbench for the multi-lane SHA-256 compression engine.
// Depends on shamc_pkg for the beat types and codes, and on the top level.
`timescale 1ns / 1ps

module sha256_multilane_compress_top_tb;
  import shamc_pkg::*;

  // Number of random command beats after the directed table.
  localparam int RAND_BEATS   = 2000;
  // Number of rows in the directed table.
  localparam int DIR_ROWS     = 25;
  // Cycles the receiver refuses results during the long hold-off.
  localparam int HOLD_CYCLES  = 300;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  // Quiet cycles after the last result.
  localparam int TAIL_CYCLES  = 100;

  // The command code that the engine ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // SHA-256 round constants, first round in the top word.
  localparam logic [64*32-1:0] ROUND_CONST = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // How a directed row is checked: against the lane model, against a result
  // typed into the table, or as a beat that must not produce any result.
  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_NONE  = 2'd1,
    CHK_GIVEN = 2'd2
  } row_chk_t;

  typedef struct packed {
    cmd_t     beat;
    row_chk_t chk;
    rsp_t     want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // Lane state as the engine should hold it.
  logic [31:0] chain_st [LANES][8];
  logic [31:0] msg_st   [LANES][16];
  logic [3:0]  cnt_st   [LANES];

  // Results still owed by the engine, oldest first.
  rsp_t due_rsp [$];

  int errors      = 0;
  int idle_cycles = 0;
  int beats_sent  = 0;
  int done_seen   = 0;
  int reads_seen  = 0;

  // Idle percentages of each side, changed by the stimulus per phase.
  int src_idle_pct = 0;
  int rcv_idle_pct = 0;
  // Set by the stimulus to make the receiver stall for HOLD_CYCLES.
  bit hold_req = 1'b0;

  dir_row_t dir_rows [DIR_ROWS];

  sha256_multilane_compress_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Runs the 64 rounds on one lane's buffered block and folds the working
  // variables back into its chaining words. The schedule lives in a ring of
  // sixteen words, each slot rewritten in place from round 16 on.
  function automatic void hash_lane_block(input int ln);
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] t1, t2, a, b, s0, s1;
    int s;
    for (int i = 0; i < 16; i++) w[i] = msg_st[ln][i];
    for (int i = 0; i < 8; i++) v[i] = chain_st[ln][i];
    for (int t = 0; t < 64; t++) begin
      s = t % 16;
      if (t >= 16) begin
        a = w[(s + 1) % 16];
        b = w[(s + 14) % 16];
        s0 = ror(a, 7) ^ ror(a, 18) ^ (a >> 3);
        s1 = ror(b, 17) ^ ror(b, 19) ^ (b >> 10);
        w[s] = w[s] + s0 + s1 + w[(s + 9) % 16];
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6]))
         + ROUND_CONST[(63 - t) * 32 +: 32] + w[s];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_st[ln][i] = chain_st[ln][i] + v[i];
  endfunction

  // Updates the lane state for one accepted command beat and reports the
  // result beat it should produce, if any.
  task automatic apply_beat(input cmd_t c, output bit has_rsp, output rsp_t r);
    int ln;
    int ix;
    logic [3:0] n;
    has_rsp = 1'b0;
    r = '0;
    ln = c.lane;
    ix = c.word_index;
    if (ln >= LANES) return;
    case (c.command)
      CMD_LOAD: begin
        chain_st[ln][ix] = c.data_word;
      end
      CMD_MSG: begin
        n = cnt_st[ln];
        msg_st[ln][n] = c.data_word;
        if (n == 4'd15) begin
          hash_lane_block(ln);
          cnt_st[ln] = 4'd0;
          has_rsp = 1'b1;
          r.result_kind = RK_DONE;
          r.result_lane = c.lane;
        end else begin
          cnt_st[ln] = n + 4'd1;
        end
      end
      CMD_READ: begin
        has_rsp = 1'b1;
        r.result_kind  = RK_READ;
        r.result_lane  = c.lane;
        r.result_index = c.word_index;
        r.result_data  = chain_st[ln][ix];
      end
      default: begin
      end
    endcase
  endtask

  // Random word that lands on all zeros or all ones now and then.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t noise_beat();
    cmd_t c;
    c.command    = 2'($urandom_range(3));
    c.lane       = 3'($urandom_range(7));
    c.word_index = 3'($urandom_range(7));
    c.data_word  = rand_word();
    return c;
  endfunction

  // Offers one command beat, entered and left at a falling edge. Valid is
  // left high on return, so back-to-back beats never drop it in between;
  // the next call lowers it only if it decides to idle first. Once the beat
  // is accepted the lane state is advanced and the owed result queued.
  task automatic issue(input cmd_t c, input row_chk_t chk, input rsp_t want);
    bit   has_rsp;
    rsp_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_valid <= 1'b0;
      cmd       <= noise_beat();
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    apply_beat(c, has_rsp, r);
    if (chk == CHK_MODEL && has_rsp) due_rsp.push_back(r);
    if (chk == CHK_GIVEN) due_rsp.push_back(want);
    if (c.command != CMD_UNUSED) beats_sent++;
    @(negedge clk);
  endtask

  // Drops valid and holds off until every owed result has come back.
  task automatic drain();
    cmd_valid <= 1'b0;
    @(negedge clk);
    while (due_rsp.size() != 0) @(negedge clk);
  endtask

  // Receiver: random back-pressure, or one long refusal when asked for.
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Result checker and activity counter. Both channels are sampled at the
  // rising edge, before the engine's own updates of that edge take effect.
  always @(posedge clk) begin : result_check
    rsp_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (rsp_valid && rsp_ready) begin
        if (due_rsp.size() == 0) begin
          errors++;
          $error("result beat with nothing owed: kind %0d lane %0d",
                 rsp.result_kind, rsp.result_lane);
        end else begin
          want = due_rsp.pop_front();
          if (rsp.result_kind !== want.result_kind) begin
            errors++;
            $error("result_kind: expected %0d, got %0d", want.result_kind,
                   rsp.result_kind);
          end
          if (rsp.result_lane !== want.result_lane) begin
            errors++;
            $error("result_lane: expected %0d, got %0d", want.result_lane,
                   rsp.result_lane);
          end
          if (rsp.result_index !== want.result_index) begin
            errors++;
            $error("result_index: expected %0d, got %0d", want.result_index,
                   rsp.result_index);
          end
          if (rsp.result_data !== want.result_data) begin
            errors++;
            $error("result_data: expected %h, got %h", want.result_data,
                   rsp.result_data);
          end
          if (want.result_kind == RK_DONE) done_seen++;
          else reads_seen++;
        end
      end
    end
  end

  // A hung handshake ends the run instead of letting it spin forever.
  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("sha256_multilane_compress_top: mismatch");
    $finish;
  end

  // Stimulus: reset, the directed table, then three random phases.
  initial begin : stimulus
    logic [31:0] pat;
    row_chk_t    chk;
    cmd_t        c;
    int          rand_start;
    int          ln;
    int          n;
    int          r;

    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    foreach (chain_st[a, b]) chain_st[a][b] = '0;
    foreach (msg_st[a, b]) msg_st[a][b] = '0;
    foreach (cnt_st[a]) cnt_st[a] = '0;

    // Directed rows. Reads right after reset must return zero, a load of
    // all ones must read back unchanged, and the unused command code must
    // leave the addressed word alone.
    dir_rows[0] = {CMD_READ, 3'd0, 3'd0, 32'h0, CHK_GIVEN,
                   RK_READ, 3'd0, 3'd0, 32'h0};
    dir_rows[1] = {CMD_READ, 3'd7, 3'd7, 32'hffff_ffff, CHK_GIVEN,
                   RK_READ, 3'd7, 3'd7, 32'h0};
    dir_rows[2] = {CMD_LOAD, 3'd7, 3'd7, 32'hffff_ffff, CHK_NONE,
                   RK_READ, 3'd0, 3'd0, 32'h0};
    dir_rows[3] = {CMD_READ, 3'd7, 3'd7, 32'h0, CHK_GIVEN,
                   RK_READ, 3'd7, 3'd7, 32'hffff_ffff};
    dir_rows[4] = {CMD_LOAD, 3'd0, 3'd0, 32'h0, CHK_NONE,
                   RK_READ, 3'd0, 3'd0, 32'h0};
    dir_rows[5] = {CMD_UNUSED, 3'd3, 3'd5, 32'hffff_ffff, CHK_NONE,
                   RK_READ, 3'd0, 3'd0, 32'h0};
    dir_rows[6] = {CMD_READ, 3'd3, 3'd5, 32'h0, CHK_GIVEN,
                   RK_READ, 3'd3, 3'd5, 32'h0};
    // One full block on lane 0 from the all-zero chaining value. Only the
    // sixteenth word answers, with a block-done beat of fixed shape.
    for (int i = 0; i < 16; i++) begin
      pat = (i == 0) ? 32'hffff_ffff : (i == 15) ? 32'h0 : 32'h9e37_79b9 * i;
      chk = (i == 15) ? CHK_GIVEN : CHK_NONE;
      dir_rows[7 + i] = {CMD_MSG, 3'd0, 3'(7 - (i % 8)), pat, chk,
                         RK_DONE, 3'd0, 3'd0, 32'h0};
    end
    // The compressed chaining words are left to the lane model.
    dir_rows[23] = {CMD_READ, 3'd0, 3'd0, 32'h0, CHK_MODEL,
                    RK_READ, 3'd0, 3'd0, 32'h0};
    dir_rows[24] = {CMD_READ, 3'd0, 3'd7, 32'h0, CHK_MODEL,
                    RK_READ, 3'd0, 3'd0, 32'h0};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_idle_pct = 23;
    rcv_idle_pct = 82;
    foreach (dir_rows[i]) issue(dir_rows[i].beat, dir_rows[i].chk, dir_rows[i].want);

    // Random phases. Most of the traffic is whole blocks on one lane, with
    // stray beats to other lanes mixed in between message words, plus full
    // loads and readbacks of a lane's chaining words and some pure noise.
    rand_start = beats_sent;
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 82 : 0;
      rcv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 23 : 0;
      if (ph == 2) begin
        // The receiver stalls while a run of reads keeps coming, so the
        // output side fills up and the engine has to refuse commands.
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++) begin
          c = {CMD_READ, 3'($urandom_range(7)), 3'($urandom_range(7)), rand_word()};
          issue(c, CHK_MODEL, '0);
        end
      end
      while (beats_sent < rand_start + (ph + 1) * RAND_BEATS / 3) begin
        r  = $urandom_range(99);
        ln = $urandom_range(LANES - 1);
        if (r < 10) begin
          for (int k = 0; k < 8; k++) begin
            c = {CMD_LOAD, 3'(ln), 3'(k), rand_word()};
            issue(c, CHK_MODEL, '0);
          end
        end else if (r < 55) begin
          // Finish whatever block the lane has started; the run ends in a compression
          // unless a noise beat sends message words to the same lane.
          n = 16 - cnt_st[ln];
          for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 15) issue(noise_beat(), CHK_MODEL, '0);
            c = {CMD_MSG, 3'(ln), 3'($urandom_range(7)), rand_word()};
            issue(c, CHK_MODEL, '0);
          end
        end else if (r < 70) begin
          for (int k = 0; k < 8; k++) begin
            c = {CMD_READ, 3'(ln), 3'(k), rand_word()};
            issue(c, CHK_MODEL, '0);
          end
        end else begin
          issue(noise_beat(), CHK_MODEL, '0);
        end
      end
      // The sender pauses until the engine has answered everything.
      if (ph < 2) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d command beats under three idling mixes and a long output stall;",
             beats_sent);
    $display("checked %0d block completions and %0d chaining word reads.",
             done_seen, reads_seen);
    if (errors == 0) begin
      $display("sha256_multilane_compress_top: match");
    end else begin
      $display("sha256_multilane_compress_top: mismatch");
    end
    $finish;
  end

endmodule
